>>> rtl/hts_pkg.sv
// Package for the heap timer scheduler: sizes, command and status codes,
// and the word and heap entry types. Depends on nothing.
package hts_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int MAX_FIRES   = 16;
	localparam int IDX_W  = $clog2(TIMER_SLOTS);
	localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
	localparam int KID_W  = IDX_W + 2;
	localparam int FIRE_W = $clog2(MAX_FIRES + 1);
	localparam int TIME_W = 48;
	localparam int PER_W  = 32;
	localparam int REP_W  = 16;
	localparam int ID_W   = 16;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic [1:0] CMD_REG   = 2'd0;
	localparam logic [1:0] CMD_UNREG = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [2:0] ST_REGISTERED = 3'd0;
	localparam logic [2:0] ST_REMOVED    = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [2:0] ST_FULL       = 3'd3;
	localparam logic [2:0] ST_FIRED      = 3'd4;
	localparam logic [2:0] ST_NONE       = 3'd5;

	typedef struct packed {
		logic [1:0]        command;
		logic [TIME_W-1:0] now_ms;
		logic [PER_W-1:0]  period_ms;
		logic [PER_W-1:0]  first_delay_ms;
		logic [REP_W-1:0]  repeat_count;
		logic [ID_W-1:0]   target_id;
	} cmd_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [ID_W-1:0] timer_id;
		logic            last;
	} rsp_t;

	typedef struct packed {
		logic [TIME_W-1:0] expiry;
		logic [PER_W-1:0]  period;
		logic [REP_W-1:0]  repeats;
		logic [ID_W-1:0]   id;
	} entry_t;

endpackage

>>> rtl/hts_cell.sv
// One heap position: holds a timer entry, compares it with its parent
// position and matches its id. Depends on hts_pkg.
module hts_cell import hts_pkg::*; (
	input  logic              clk,
	input  logic              wr_en,
	input  entry_t            wr_data,
	input  logic [TIME_W-1:0] parent_expiry,
	input  logic              has_parent,
	input  logic [ID_W-1:0]   target_id,
	output entry_t            data,
	output logic              lt_parent,
	output logic              id_hit
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_data;
		end
	end

	assign data      = entry_q;
	assign lt_parent = has_parent && (entry_q.expiry < parent_expiry);
	assign id_hit    = (entry_q.id == target_id);

endmodule

>>> rtl/hts_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
// Depends on hts_pkg.
module hts_rem import hts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	input  logic [PER_W-1:0]  divisor,
	output logic              done,
	output logic [PER_W-1:0]  rem
);

	localparam int BIT_W = $clog2(TIME_W + 1);

	logic [TIME_W-1:0] dvd_q;
	logic [PER_W-1:0]  dvs_q;
	logic [PER_W-1:0]  rem_q;
	logic [BIT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [PER_W:0]    trial;
	logic [PER_W:0]    diff;

	assign trial = {rem_q, dvd_q[TIME_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= BIT_W'(TIME_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == BIT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			if (!diff[PER_W]) begin
				rem_q <= diff[PER_W-1:0];
			end else begin
				rem_q <= trial[PER_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> rtl/heap_timer_scheduler.sv
// Heap timer scheduler: a row of heap cells under a sift sequencer.
// A register loads the new entry at the heap tail and sifts it up, or answers
// full when the heap is full; an unregister answers not found on a miss, and on
// a hit drops the entry and sifts its replacement. A tick fires due timers in turn:
// a timer that stays has its expiry realigned by the remainder unit and is sifted
// down, and one whose last repeat it was is dropped from the heap.
// One word is worked on at a time; the next is taken once the sequencer is back
// in idle, which it enters as the last result is written to the output register.
// Reset clears the heap count, id counter and control.
module heap_timer_scheduler import hts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_START    = 8'b0000_0010,
		S_SIFT_UP  = 8'b0000_0100,
		S_SIFT_DN  = 8'b0000_1000,
		S_DROP     = 8'b0001_0000,
		S_DROP_CHK = 8'b0010_0000,
		S_TICK_CHK = 8'b0100_0000,
		S_TICK_MOD = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [ID_W-1:0]   idc_q, idc_d;
	logic [IDX_W-1:0]  pos_q, pos_d;
	logic [FIRE_W-1:0] fires_q, fires_d;
	logic [ID_W-1:0]   held_q, held_d;
	logic              held_v_q, held_v_d;
	logic [2:0]        res_st_q, res_st_d;
	logic [ID_W-1:0]   res_id_q, res_id_d;
	logic              fin_q, fin_d;
	logic              out_valid_q;
	rsp_t              out_q;

	entry_t cell_d [TIMER_SLOTS];
	logic   cell_lt [TIMER_SLOTS];
	logic   cell_hit [TIMER_SLOTS];
	logic   cell_we [TIMER_SLOTS];
	entry_t cell_wd [TIMER_SLOTS];

	logic             sw_en, ld_en;
	logic [IDX_W-1:0] sw_a, sw_b, ld_idx;
	entry_t           ld_data;
	logic             push;
	rsp_t             push_w;
	logic             out_free;
	logic             rem_start, rem_done;
	logic [PER_W-1:0] rem_val;

	genvar g;
	generate
		for (g = 0; g < TIMER_SLOTS; g++) begin : g_cell
			hts_cell u_cell (
				.clk          (clk),
				.wr_en        (cell_we[g]),
				.wr_data      (cell_wd[g]),
				.parent_expiry(cell_d[(g == 0) ? 0 : (g - 1) / 2].expiry),
				.has_parent   (g != 0),
				.target_id    (cmd_q.target_id),
				.data         (cell_d[g]),
				.lt_parent    (cell_lt[g]),
				.id_hit       (cell_hit[g])
			);
		end
	endgenerate

	hts_rem u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend(cmd_q.now_ms - cell_d[0].expiry),
		.divisor (cell_d[0].period),
		.done    (rem_done),
		.rem     (rem_val)
	);

	// Per-cell writes: an exchange of two positions, or a load of one.
	always_comb begin
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			cell_we[i] = 1'b0;
			cell_wd[i] = ld_data;
			if (sw_en && sw_a == IDX_W'(i)) begin
				cell_we[i] = 1'b1;
				cell_wd[i] = cell_d[sw_b];
			end else if (sw_en && sw_b == IDX_W'(i)) begin
				cell_we[i] = 1'b1;
				cell_wd[i] = cell_d[sw_a];
			end else if (ld_en && ld_idx == IDX_W'(i)) begin
				cell_we[i] = 1'b1;
			end
		end
	end

	assign out_free  = !out_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE);

	logic [PER_W-1:0]  per_eff, dly_eff;
	logic [TIME_W:0]   exp_sum, next_sum;
	logic [TIME_W-1:0] next_base;
	logic              hit_any;
	logic [IDX_W-1:0]  hit_idx;
	logic [IDX_W-1:0]  parent;
	logic [KID_W-1:0]  kid, kid1;
	logic [IDX_W-1:0]  pick;
	logic              fire;
	logic [CNT_W-1:0]  tail;

	always_comb begin
		per_eff   = (cmd_q.period_ms == '0) ? PER_W'(1) : cmd_q.period_ms;
		dly_eff   = (cmd_q.first_delay_ms == '0) ? per_eff : cmd_q.first_delay_ms;
		exp_sum   = {1'b0, cmd_q.now_ms} + {{(TIME_W + 1 - PER_W){1'b0}}, dly_eff};
		next_base = cmd_q.now_ms - {{(TIME_W - PER_W){1'b0}}, rem_val};
		next_sum  = {1'b0, next_base} + {{(TIME_W + 1 - PER_W){1'b0}}, cell_d[0].period};
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (cell_hit[i] && CNT_W'(i) < count_q) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
		parent = (pos_q - 1'b1) >> 1;
		kid    = {1'b0, pos_q, 1'b1};
		kid1   = kid + 1'b1;
		pick   = kid[IDX_W-1:0];
		if (KID_W'(count_q) > kid1 &&
		    !(cell_d[kid[IDX_W-1:0]].expiry < cell_d[kid1[IDX_W-1:0]].expiry)) begin
			pick = kid1[IDX_W-1:0];
		end
		fire = (count_q != '0) && (cell_d[0].expiry <= cmd_q.now_ms) &&
		       (fires_q < FIRE_W'(MAX_FIRES));
		tail = count_q - 1'b1;
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idc_d    = idc_q;
		pos_d    = pos_q;
		fires_d  = fires_q;
		held_d   = held_q;
		held_v_d = held_v_q;
		res_st_d = res_st_q;
		res_id_d = res_id_q;
		fin_d    = fin_q;
		sw_en    = 1'b0;
		sw_a     = '0;
		sw_b     = '0;
		ld_en    = 1'b0;
		ld_idx   = '0;
		ld_data  = cell_d[0];
		push     = 1'b0;
		push_w   = '{status: res_st_q, timer_id: res_id_q, last: 1'b1};
		rem_start = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				fin_d = 1'b0;
				if (cmd_valid) begin
					state_d = S_START;
				end else if (fin_q) begin
					// A leftover finish flag is cleared; results wait for the output slot in their own state.
					fin_d = 1'b0;
				end
			end
			S_START: begin
				priority case (cmd_q.command)
					CMD_REG: begin
						if (count_q >= CNT_W'(TIMER_SLOTS)) begin
							res_st_d = ST_FULL;
							res_id_d = '0;
							fin_d    = 1'b1;
						end else begin
							idc_d = (idc_q == '1) ? ID_W'(1) : idc_q + 1'b1;
							ld_en  = 1'b1;
							ld_idx = count_q[IDX_W-1:0];
							ld_data.expiry  = exp_sum[TIME_W] ? TIME_MAX : exp_sum[TIME_W-1:0];
							ld_data.period  = per_eff;
							ld_data.repeats = cmd_q.repeat_count;
							ld_data.id      = (idc_q == '1) ? ID_W'(1) : idc_q + 1'b1;
							count_d  = count_q + 1'b1;
							pos_d    = count_q[IDX_W-1:0];
							res_st_d = ST_REGISTERED;
							res_id_d = ld_data.id;
							state_d  = S_SIFT_UP;
						end
					end
					CMD_UNREG: begin
						if (hit_any && cmd_q.target_id != '0) begin
							pos_d    = hit_idx;
							res_st_d = ST_REMOVED;
							res_id_d = cmd_q.target_id;
							state_d  = S_DROP;
						end else begin
							res_st_d = ST_NOT_FOUND;
							res_id_d = '0;
							fin_d    = 1'b1;
						end
					end
					CMD_TICK: begin
						fires_d  = '0;
						held_v_d = 1'b0;
						state_d  = S_TICK_CHK;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SIFT_UP: begin
				if (pos_q != '0 && cell_lt[pos_q]) begin
					sw_en = 1'b1;
					sw_a  = pos_q;
					sw_b  = parent;
					pos_d = parent;
				end else begin
					state_d = (cmd_q.command == CMD_TICK) ? S_TICK_CHK : S_START;
					fin_d   = (cmd_q.command != CMD_TICK);
				end
			end
			S_SIFT_DN: begin
				if (KID_W'(count_q) > kid &&
				    !(cell_d[pos_q].expiry < cell_d[pick].expiry)) begin
					sw_en = 1'b1;
					sw_a  = pos_q;
					sw_b  = pick;
					pos_d = pick;
				end else begin
					state_d = (cmd_q.command == CMD_TICK) ? S_TICK_CHK : S_START;
					fin_d   = (cmd_q.command != CMD_TICK);
				end
			end
			S_DROP: begin
				if (CNT_W'(pos_q) != tail) begin
					sw_en = 1'b1;
					sw_a  = pos_q;
					sw_b  = tail[IDX_W-1:0];
				end
				count_d = tail;
				state_d = S_DROP_CHK;
			end
			S_DROP_CHK: begin
				if (CNT_W'(pos_q) < count_q) begin
					state_d = (pos_q != '0 && cell_lt[pos_q]) ? S_SIFT_UP : S_SIFT_DN;
				end else begin
					state_d = (cmd_q.command == CMD_TICK) ? S_TICK_CHK : S_START;
					fin_d   = (cmd_q.command != CMD_TICK);
				end
			end
			S_TICK_CHK: begin
				if (fire) begin
					if (!held_v_q || out_free) begin
						push     = held_v_q;
						push_w   = '{status: ST_FIRED, timer_id: held_q, last: 1'b0};
						held_d   = cell_d[0].id;
						held_v_d = 1'b1;
						fires_d  = fires_q + 1'b1;
						pos_d    = '0;
						if (cell_d[0].repeats == REP_W'(1)) begin
							state_d = S_DROP;
						end else begin
							if (cell_d[0].repeats > REP_W'(1)) begin
								ld_en = 1'b1;
								ld_idx = '0;
								ld_data.repeats = cell_d[0].repeats - 1'b1;
							end
							rem_start = 1'b1;
							state_d   = S_TICK_MOD;
						end
					end
				end else if (out_free) begin
					push = 1'b1;
					if (held_v_q) begin
						push_w = '{status: ST_FIRED, timer_id: held_q, last: 1'b1};
					end else begin
						push_w = '{status: ST_NONE, timer_id: '0, last: 1'b1};
					end
					state_d = S_IDLE;
				end
			end
			S_TICK_MOD: begin
				if (rem_done) begin
					ld_en  = 1'b1;
					ld_idx = '0;
					ld_data.expiry = next_sum[TIME_W] ? TIME_MAX : next_sum[TIME_W-1:0];
					pos_d   = '0;
					state_d = S_SIFT_DN;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Single-result commands finish by handing their word to the output.
		// While the output is busy the sequencer holds in its current state.
		if (fin_d && state_q != S_IDLE) begin
			if (out_free) begin
				push    = 1'b1;
				push_w  = '{status: res_st_d, timer_id: res_id_d, last: 1'b1};
				fin_d   = 1'b0;
				state_d = S_IDLE;
			end else begin
				state_d = state_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idc_q       <= '0;
			held_v_q    <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			idc_q    <= idc_d;
			held_v_q <= held_v_d;
			fin_q    <= fin_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
		pos_q    <= pos_d;
		fires_q  <= fires_d;
		held_q   <= held_d;
		res_st_q <= res_st_d;
		res_id_q <= res_id_d;
		if (push) begin
			out_q <= push_w;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
